// File: src/ipd_pkg.sv
package ipd_pkg;

	localparam int LEN_W  = 17;
	localparam int TICK_W = 16;
	localparam int WIN_N  = 6;
	localparam int IPD_N  = 5;

	typedef logic [7:0] byte_t;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_TICK  = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		EV_DATA    = 2'd0,
		EV_CLOSED  = 2'd1,
		EV_TIMEOUT = 2'd2
	} event_t;

	typedef enum logic [1:0] {
		PH_DONE = 2'd0,
		PH_HUNT = 2'd1,
		PH_LEN  = 2'd2,
		PH_DATA = 2'd3
	} phase_t;

	typedef struct packed {
		logic [1:0] opcode;
		byte_t      rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] event_res;
		byte_t      payload;
	} out_item_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} result_t;

	localparam byte_t TOK_CLOSED [WIN_N] = '{"C", "L", "O", "S", "E", "D"};
	localparam byte_t TOK_IPD    [IPD_N] = '{"+", "I", "P", "D", ","};
	localparam byte_t CHR_COLON  = ":";
	localparam byte_t CHR_ZERO   = "0";
	localparam byte_t CHR_NINE   = "9";
	localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd8000;

endpackage

// File: src/ipd_stream_if.sv
interface ipd_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: src/ipd_chunk_deframer_top.sv
// Modem receive deframer. Items carry a start, a received byte or a millisecond
// tick; results carry a payload byte, a closed event or a timeout event. One
// item is taken every cycle while the output buffer has room; a result is
// formed combinationally from the input register by the state update of the
// window match, length accumulator and counters, then registered in the
// two-entry output buffer, which keeps input flowing while a result waits to be taken.
// The timeout register should be written only while no item is in flight.
module ipd_chunk_deframer_top import ipd_pkg::*; #(
	parameter int LENGTH_CHARS = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	ipd_stream_if.sink        rx_in,
	ipd_stream_if.source      ev_out,
	input  logic              cfg_we,
	input  logic [TICK_W-1:0] cfg_wdata
);

	logic     take;
	logic     valid_s1;
	in_item_t item_s1;
	logic     buf_ready;
	result_t  res;

	ipd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_in    (rx_in),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ipd_core #(.LENGTH_CHARS(LENGTH_CHARS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.buf_ready (buf_ready),
		.take      (take),
		.res       (res)
	);

	ipd_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.buf_ready (buf_ready),
		.ev_out    (ev_out)
	);

endmodule

// File: src/ipd_in_stage.sv
module ipd_in_stage import ipd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ipd_stream_if.sink   rx_in,
	input  logic         take,
	output logic         valid_s1,
	output in_item_t     item_s1
);

	logic v_s1;

	assign rx_in.ready = !v_s1 || take;
	assign valid_s1    = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx_in.ready) begin
			v_s1 <= rx_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_in.ready && rx_in.valid) begin
			item_s1 <= rx_in.data;
		end
	end

endmodule

// File: src/ipd_core.sv
module ipd_core import ipd_pkg::*; #(
	parameter int LENGTH_CHARS = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [TICK_W-1:0] cfg_wdata,
	input  logic              valid_s1,
	input  in_item_t          item_s1,
	input  logic              buf_ready,
	output logic              take,
	output result_t           res
);

	localparam int LC_W = $clog2(LENGTH_CHARS + 1);

	logic [TICK_W-1:0] timeout_q;
	byte_t             win_q [WIN_N];
	byte_t             win_n [WIN_N];
	phase_t            phase_q, phase_n;
	logic [LEN_W-1:0]  left_q, left_n;
	logic [LEN_W-1:0]  acc_q, acc_n;
	logic [LC_W-1:0]   chars_q, chars_n;
	logic              stopped_q, stopped_n;
	logic              digit_q, digit_n;
	logic [TICK_W-1:0] ticks_q, ticks_n;
	byte_t             shifted [WIN_N];
	logic              hit_closed, hit_ipd;
	logic [LEN_W-1:0]  acc_x10;
	byte_t             b;

	assign take = valid_s1 && buf_ready;
	assign b    = item_s1.rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_comb begin
		for (int i = 0; i < WIN_N - 1; i++) begin
			shifted[i] = win_q[i+1];
		end
		shifted[WIN_N-1] = b;
		hit_closed = 1'b1;
		for (int i = 0; i < WIN_N; i++) begin
			if (shifted[i] != TOK_CLOSED[i]) hit_closed = 1'b0;
		end
		hit_ipd = 1'b1;
		for (int i = 0; i < IPD_N; i++) begin
			if (shifted[WIN_N-IPD_N+i] != TOK_IPD[i]) hit_ipd = 1'b0;
		end
	end

	assign acc_x10 = (acc_q << 3) + (acc_q << 1) + LEN_W'(b - CHR_ZERO);

	always_comb begin
		win_n     = win_q;
		phase_n   = phase_q;
		left_n    = left_q;
		acc_n     = acc_q;
		chars_n   = chars_q;
		stopped_n = stopped_q;
		digit_n   = digit_q;
		ticks_n   = ticks_q;
		res       = '0;
		if (take) begin
			case (item_s1.opcode)
				OP_START: begin
					for (int i = 0; i < WIN_N; i++) win_n[i] = '0;
					left_n    = '0;
					acc_n     = '0;
					chars_n   = '0;
					stopped_n = 1'b0;
					digit_n   = 1'b0;
					ticks_n   = timeout_q;
					phase_n   = PH_HUNT;
				end
				OP_TICK: begin
					if (phase_q != PH_DONE) begin
						if (ticks_q <= TICK_W'(1)) begin
							ticks_n        = '0;
							phase_n        = PH_DONE;
							res.valid      = 1'b1;
							res.item.event_res = EV_TIMEOUT;
						end else begin
							ticks_n = ticks_q - TICK_W'(1);
						end
					end
				end
				OP_BYTE: begin
					case (phase_q)
						PH_DATA: begin
							left_n = left_q - LEN_W'(1);
							if (left_n == '0) phase_n = PH_HUNT;
							res.valid          = 1'b1;
							res.item.event_res = EV_DATA;
							res.item.payload   = b;
						end
						PH_LEN: begin
							if (b == CHR_COLON) begin
								left_n  = acc_q;
								phase_n = (acc_q != '0) ? PH_DATA : PH_HUNT;
							end else if (chars_q < LC_W'(LENGTH_CHARS)) begin
								chars_n = chars_q + LC_W'(1);
								if (!stopped_q) begin
									if (b >= CHR_ZERO && b <= CHR_NINE) begin
										acc_n   = acc_x10;
										digit_n = 1'b1;
									end else if (!digit_q &&
										(b inside {8'h20, [8'h09:8'h0d]})) begin
										stopped_n = 1'b0;
									end else begin
										stopped_n = 1'b1;
									end
								end
							end
						end
						PH_HUNT: begin
							win_n = shifted;
							if (hit_closed) begin
								phase_n            = PH_DONE;
								res.valid          = 1'b1;
								res.item.event_res = EV_CLOSED;
							end else if (hit_ipd) begin
								acc_n     = '0;
								chars_n   = '0;
								stopped_n = 1'b0;
								digit_n   = 1'b0;
								phase_n   = PH_LEN;
							end
						end
						default: begin
							phase_n = PH_DONE;
						end
					endcase
				end
				default: begin
					phase_n = phase_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_DONE;
			for (int i = 0; i < WIN_N; i++) win_q[i] <= '0;
			left_q    <= '0;
			acc_q     <= '0;
			chars_q   <= '0;
			stopped_q <= 1'b0;
			digit_q   <= 1'b0;
			ticks_q   <= '0;
		end else begin
			phase_q   <= phase_n;
			win_q     <= win_n;
			left_q    <= left_n;
			acc_q     <= acc_n;
			chars_q   <= chars_n;
			stopped_q <= stopped_n;
			digit_q   <= digit_n;
			ticks_q   <= ticks_n;
		end
	end

	a_data_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> left_q != '0)
		else $error("data phase with no bytes left");

	a_event_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.item.event_res != EV_DATA |-> res.item.payload == '0)
		else $error("event carries a payload byte");

	a_event_ends_stream: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.item.event_res != EV_DATA |=> phase_q == PH_DONE)
		else $error("stream not ended after event");

	a_result_needs_take: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> take)
		else $error("result without a transfer");

endmodule

// File: src/ipd_out_buf.sv
module ipd_out_buf import ipd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  result_t       res,
	output logic          buf_ready,
	ipd_stream_if.source  ev_out
);

	logic      out_v_q, sk_v_q;
	out_item_t out_d_q, sk_d_q;

	assign buf_ready    = !sk_v_q;
	assign ev_out.valid = out_v_q;
	assign ev_out.data  = out_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (!out_v_q || ev_out.ready) begin
			if (sk_v_q) begin
				out_v_q <= 1'b1;
				sk_v_q  <= 1'b0;
			end else begin
				out_v_q <= res.valid;
			end
		end else if (res.valid) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || ev_out.ready) begin
			if (sk_v_q) begin
				out_d_q <= sk_d_q;
			end else if (res.valid) begin
				out_d_q <= res.item;
			end
		end else if (res.valid) begin
			sk_d_q <= res.item;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> out_v_q)
		else $error("skid entry held with empty output register");

endmodule

// File: verif/ipd_chunk_deframer_top_test.sv
`timescale 1ns / 1ps

module ipd_chunk_deframer_top_test;
	import ipd_pkg::*;

	localparam int DIGITS_KEPT = 5;
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [TICK_W-1:0] cfg_wdata;

	ipd_stream_if #(.T(in_item_t)) rx_if ();
	ipd_stream_if #(.T(out_item_t)) ev_if ();

	ipd_chunk_deframer_top #(.LENGTH_CHARS(DIGITS_KEPT)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_in(rx_if),
		.ev_out(ev_if),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	in_item_t pending [$];
	out_item_t due_events [$];
	int n_queued = 0;
	int n_taken = 0;
	int faults = 0;
	int snd_wait = 0;
	int rdy_wait = 0;
	bit in_done, out_done;
	bit in_calm, out_calm;
	bit rx_hold, hold_go;

	// deframer state as predicted
	byte_t win [WIN_N];
	logic [LEN_W-1:0] data_left, len_val;
	logic [2:0] len_cnt;
	bit len_halt, len_digit;
	logic [TICK_W-1:0] ticks;
	logic [TICK_W-1:0] timeout_reg = TIMEOUT_RESET;
	phase_t ph = PH_DONE;

	function automatic int pause(bit calm);
		if (calm || $urandom_range(0, 2) != 0)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	task automatic report(string msg);
		$display("%0t mismatch: %s", $time, msg);
		faults++;
	endtask

	task automatic push_event(logic [1:0] ev, byte_t b);
		out_item_t r;
		r.event_res = ev;
		r.payload = b;
		due_events.push_back(r);
	endtask

	task automatic deframe(in_item_t it);
		byte_t b;
		bit closed, ipd;
		int i;
		b = it.rx_byte;
		if (it.opcode == OP_START) begin
			win = '{default: 8'h00};
			data_left = '0;
			len_val = '0;
			len_cnt = '0;
			len_halt = 1'b0;
			len_digit = 1'b0;
			ticks = timeout_reg;
			ph = PH_HUNT;
		end else if (it.opcode == OP_SPARE || ph == PH_DONE) begin
		end else if (it.opcode == OP_TICK) begin
			if (ticks <= 1) begin
				ticks = '0;
				ph = PH_DONE;
				push_event(EV_TIMEOUT, 8'h00);
			end else begin
				ticks = ticks - 1'b1;
			end
		end else if (ph == PH_DATA) begin
			data_left = data_left - 1'b1;
			if (data_left == 0)
				ph = PH_HUNT;
			push_event(EV_DATA, b);
		end else if (ph == PH_LEN) begin
			if (b == CHR_COLON) begin
				data_left = len_val;
				ph = (len_val != 0) ? PH_DATA : PH_HUNT;
			end else if (len_cnt < DIGITS_KEPT) begin
				len_cnt = len_cnt + 1'b1;
				if (!len_halt) begin
					if (b >= CHR_ZERO && b <= CHR_NINE) begin
						len_val = len_val * 10 + (b - CHR_ZERO);
						len_digit = 1'b1;
					end else if (!len_digit && (b == 8'd32 || (b >= 8'd9 && b <= 8'd13))) begin
						// skip leading white space
					end else begin
						len_halt = 1'b1;
					end
				end
			end
		end else begin
			for (i = 0; i < WIN_N - 1; i++)
				win[i] = win[i + 1];
			win[WIN_N - 1] = b;
			closed = 1'b1;
			for (i = 0; i < WIN_N; i++)
				if (win[i] != TOK_CLOSED[i])
					closed = 1'b0;
			ipd = 1'b1;
			for (i = 0; i < IPD_N; i++)
				if (win[WIN_N - IPD_N + i] != TOK_IPD[i])
					ipd = 1'b0;
			if (closed) begin
				ph = PH_DONE;
				push_event(EV_CLOSED, 8'h00);
			end else if (ipd) begin
				len_val = '0;
				len_cnt = '0;
				len_halt = 1'b0;
				len_digit = 1'b0;
				ph = PH_LEN;
			end
		end
	endtask

	// input side: sample transfers, advance the prediction
	always @(posedge clk) begin
		in_done <= rx_if.valid && rx_if.ready;
		out_done <= ev_if.valid && ev_if.ready;
		if (arst_n && rx_if.valid && rx_if.ready) begin
			n_taken++;
			deframe(rx_if.data);
		end
	end

	// result side: compare each transfer with the oldest prediction
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && ev_if.valid && ev_if.ready) begin
			if (due_events.size() == 0) begin
				report($sformatf("unexpected event %0d payload %02h",
					ev_if.data.event_res, ev_if.data.payload));
			end else begin
				want = due_events.pop_front();
				if (ev_if.data.event_res !== want.event_res)
					report($sformatf("event %0d, predicted %0d",
						ev_if.data.event_res, want.event_res));
				if (ev_if.data.payload !== want.payload)
					report($sformatf("payload %02h, predicted %02h",
						ev_if.data.payload, want.payload));
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			rx_if.valid <= 1'b0;
		end else if (!rx_if.valid || in_done) begin
			if (snd_wait > 0) begin
				rx_if.valid <= 1'b0;
				snd_wait <= snd_wait - 1;
			end else if (pending.size() != 0) begin
				rx_if.valid <= 1'b1;
				rx_if.data <= pending.pop_front();
				snd_wait <= pause(in_calm);
			end else begin
				rx_if.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		int w;
		if (!arst_n || rx_hold) begin
			ev_if.ready <= 1'b0;
		end else if (rdy_wait > 0) begin
			ev_if.ready <= 1'b0;
			rdy_wait <= rdy_wait - 1;
		end else if (out_done) begin
			w = pause(out_calm);
			ev_if.ready <= (w == 0);
			rdy_wait <= (w > 0) ? w - 1 : 0;
		end else begin
			ev_if.ready <= 1'b1;
		end
	end

	// long receiver hold so the block fills and stalls its input
	initial begin
		wait (hold_go);
		repeat (20) @(posedge clk);
		rx_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rx_hold <= 1'b0;
	end

	task automatic offer(logic [1:0] op, byte_t b);
		in_item_t it;
		it.opcode = op;
		it.rx_byte = b;
		pending.push_back(it);
		n_queued++;
	endtask

	task automatic send_text(string s);
		for (int k = 0; k < s.len(); k++)
			offer(OP_BYTE, s[k]);
	endtask

	task automatic send_noise(int n);
		string pool = "+IPDCLOSE,:";
		for (int k = 0; k < n; k++)
			if ($urandom_range(0, 1) != 0)
				offer(OP_BYTE, 8'($urandom));
			else
				offer(OP_BYTE, pool[$urandom_range(0, pool.len() - 1)]);
	endtask

	task automatic send_chunk();
		int n, k, sel, j;
		string field;
		string ws = " \011\012\013\014\015";
		sel = $urandom_range(0, 15);
		send_noise($urandom_range(0, 2));
		send_text("+IPD,");
		if (sel == 15) begin
			case ($urandom_range(0, 5))
				0: field = "";
				1: field = "0000012";
				2: field = "7x3";
				3: field = "4 ";
				4: field = "ab";
				default: field = "\011\012\013\014\0159";
			endcase
			n = $urandom_range(0, 8);
		end else begin
			if (sel == 0)
				n = 0;
			else if (sel < 13)
				n = $urandom_range(1, 12);
			else
				n = $urandom_range(13, 60);
			field = $sformatf("%0d", n);
			if ($urandom_range(0, 3) == 0) begin
				j = $urandom_range(0, ws.len() - 1);
				field = {ws.substr(j, j), field};
			end
		end
		send_text(field);
		offer(OP_BYTE, CHR_COLON);
		k = 0;
		if (n >= 6 && $urandom_range(0, 5) == 0) begin
			send_text(($urandom_range(0, 1) != 0) ? "CLOSED" : "+IPD,:");
			k = 6;
		end
		while (k < n) begin
			if ($urandom_range(0, 29) == 0)
				offer(OP_TICK, 8'($urandom));
			offer(OP_BYTE, 8'($urandom));
			k++;
		end
	endtask

	task automatic add_session();
		int segs, r;
		offer(OP_START, 8'($urandom));
		segs = $urandom_range(1, 5);
		repeat (segs) begin
			r = $urandom_range(0, 19);
			if (r < 13)
				send_chunk();
			else if (r < 15)
				send_noise($urandom_range(1, 6));
			else if (r < 17)
				offer(OP_TICK, 8'($urandom));
			else if (r == 17)
				offer(OP_SPARE, 8'($urandom));
			else if (r == 18)
				offer(OP_START, 8'($urandom));
			else begin
				case ($urandom_range(0, 3))
					0: send_text("+IPD");
					1: send_text("CLOSE");
					2: send_text("+IP,");
					default: send_text("CLOSEd");
				endcase
			end
		end
		case ($urandom_range(0, 3))
			0: begin
				send_text("CLOSED");
				offer(OP_BYTE, 8'($urandom));
				offer(OP_TICK, 8'($urandom));
			end
			1: repeat (2) offer(OP_TICK, 8'($urandom));
			default: ;
		endcase
	endtask

	task automatic random_items(int target);
		int base;
		base = n_queued;
		while (n_queued - base < target)
			add_session();
	endtask

	task automatic settle();
		while (n_taken != n_queued || due_events.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_timeout(logic [TICK_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		timeout_reg = v;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		rx_if.valid = 1'b0;
		rx_if.data = '0;
		ev_if.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_timeout(16'd2);
		offer(OP_BYTE, "C");
		offer(OP_TICK, 8'hFF);
		offer(OP_SPARE, 8'hFF);
		offer(OP_START, 8'h00);
		send_text("+IPD, 2:");
		offer(OP_BYTE, 8'h00);
		offer(OP_BYTE, 8'hFF);
		send_text("+IPD,:");
		offer(OP_TICK, 8'h00);
		offer(OP_TICK, 8'h00);
		offer(OP_BYTE, "x");
		settle();

		in_calm = 1'b1;
		set_timeout(16'd1);
		random_items(220);
		settle();

		in_calm = 1'b0;
		out_calm = 1'b1;
		set_timeout(16'd0);
		random_items(220);
		settle();

		in_calm = 1'b1;
		out_calm = 1'b0;
		set_timeout(16'hFFFF);
		offer(OP_START, 8'h00);
		send_text("+IPD,300:");
		repeat (300) offer(OP_BYTE, 8'($urandom));
		send_text("CLOSED");
		hold_go = 1'b1;
		random_items(120);
		settle();

		in_calm = 1'b0;
		set_timeout(TIMEOUT_RESET);
		random_items(220);
		settle();

		set_timeout(16'($urandom_range(3, 40)));
		random_items(220);
		settle();

		set_timeout(16'($urandom_range(1, 65535)));
		random_items(220);
		settle();

		if (faults == 0)
			$display("ipd_chunk_deframer_top_test OK");
		else
			$display("ipd_chunk_deframer_top_test NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("ipd_chunk_deframer_top_test NOT OK");
		$finish;
	end

endmodule
